/* rtl/core/bde_pkg.sv */
`default_nettype none

package bde_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OCC_W  = 5;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

/* rtl/core/bounded_deque_engine.sv */
`default_nettype none

// Bounded double-ended queue of signed words in a ring of DEPTH entries.
// Command channel: an operation word (operation, push_value) is taken at
// a rising edge with start high and busy low. Operations are push front,
// push back, pop front and pop back.
// Result channel: exactly one result word per operation, shown for one
// cycle with done high: popped_value, status (ok, full, empty) and the
// occupancy after the operation. The receiver cannot stall; a result that
// is not taken in its cycle is gone.
// Latency: the result appears in the cycle after the command is taken;
// the pop data comes straight from the registered read port of the
// element memory.
// Throughput: one operation per cycle. Head and count update at the edge
// that takes the command; each operation touches at most one entry through
// one write port or one read port; a read always lands at a later edge than
// the write it depends on, so no forwarding is needed. busy stays low.
// Reset: asynchronous, active low; the deque comes up empty with head at
// slot zero. Memory contents are not cleared, and only written entries
// are ever read.
module bounded_deque_engine #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [1:0]                             operation,
	input  wire logic signed [bde_pkg::WORD_W-1:0]      push_value,
	output logic                                        done,
	output logic signed [bde_pkg::WORD_W-1:0]           popped_value,
	output logic [1:0]                                  status,
	output logic [bde_pkg::OCC_W-1:0]                   occupancy
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;

	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic                   done_q;
	logic                   pop_ok_s1;
	bde_pkg::status_t       status_q;
	logic [bde_pkg::OCC_W-1:0] occupancy_q;

	bde_pkg::op_t      op;
	logic              accept;
	logic              is_push, is_full, is_empty;
	logic [SW-1:0]     sum, sum_m1;
	logic [IW-1:0]     back_free, back_last, head_dec, head_inc;
	logic [IW-1:0]     head_next;
	logic [CW-1:0]     count_next;
	bde_pkg::status_t  status_next;
	logic              we, re;
	logic [IW-1:0]     waddr, raddr;
	logic [bde_pkg::WORD_W-1:0] rdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op     = bde_pkg::op_t'(operation);

	assign is_push  = (op == bde_pkg::OP_PUSH_FRONT) || (op == bde_pkg::OP_PUSH_BACK);
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// ring positions: sums stay below 2*DEPTH, so one conditional subtract wraps them
	assign sum       = SW'(head_q) + SW'(count_q);
	assign sum_m1    = sum - SW'(1);
	assign back_free = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);
	assign back_last = (sum_m1 >= SW'(DEPTH)) ? IW'(sum_m1 - SW'(DEPTH)) : IW'(sum_m1);
	assign head_dec  = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
	assign head_inc  = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);

	always_comb begin
		head_next   = head_q;
		count_next  = count_q;
		status_next = bde_pkg::ST_OK;
		we          = 1'b0;
		re          = 1'b0;
		waddr       = back_free;
		raddr       = head_q;
		if (is_push) begin
			if (is_full) begin
				status_next = bde_pkg::ST_FULL;
			end else begin
				we         = accept;
				count_next = count_q + CW'(1);
				if (op == bde_pkg::OP_PUSH_FRONT) begin
					head_next = head_dec;
					waddr     = head_dec;
				end
			end
		end else begin
			if (is_empty) begin
				status_next = bde_pkg::ST_EMPTY;
			end else begin
				re         = accept;
				count_next = count_q - CW'(1);
				if (op == bde_pkg::OP_POP_FRONT) begin
					head_next = head_inc;
				end else begin
					raddr = back_last;
				end
				if (count_q == CW'(1)) begin
					head_next = '0;
				end
			end
		end
	end

	bde_ram #(
		.WIDTH(bde_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (push_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
			pop_ok_s1 <= 1'b0;
		end else begin
			done_q    <= accept;
			pop_ok_s1 <= re;
			if (accept) begin
				head_q  <= head_next;
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_next;
			occupancy_q <= bde_pkg::OCC_W'(count_next);
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign occupancy    = occupancy_q;
	assign popped_value = pop_ok_s1 ? signed'(rdata) : '0;

endmodule

`default_nettype wire

/* rtl/core/bde_ram.sv */
`default_nettype none

module bde_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned IDLE_LIMIT = 200;
	localparam int unsigned RANDOM_OPS = 1725;

	typedef struct {
		logic signed [bde_pkg::WORD_W-1:0] popped_value;
		bde_pkg::status_t                  status;
		logic [bde_pkg::OCC_W-1:0]         occupancy;
	} deque_result_t;

	class deque_scoreboard;
		logic signed [bde_pkg::WORD_W-1:0] ring [DEPTH];
		logic [3:0]                        head;
		logic [bde_pkg::OCC_W-1:0]         count;
		deque_result_t                     expected_results [$];
		int                                errors;

		function new();
			head   = '0;
			count  = '0;
			errors = 0;
		endfunction

		// predicts the result word of one accepted command and queues it
		function void note_command(bde_pkg::op_t op, logic signed [bde_pkg::WORD_W-1:0] word);
			deque_result_t r;
			logic [3:0]    slot;
			r.popped_value = '0;
			r.status       = bde_pkg::ST_OK;
			if (op == bde_pkg::OP_PUSH_FRONT || op == bde_pkg::OP_PUSH_BACK) begin
				if (count >= DEPTH) begin
					r.status = bde_pkg::ST_FULL;
				end else begin
					if (op == bde_pkg::OP_PUSH_FRONT) begin
						head = head - 4'd1;
						slot = head;
					end else begin
						slot = head + count[3:0];
					end
					ring[slot] = word;
					count      = count + 1'b1;
				end
			end else begin
				if (count == 0) begin
					r.status = bde_pkg::ST_EMPTY;
				end else begin
					if (op == bde_pkg::OP_POP_FRONT) begin
						r.popped_value = ring[head];
						head           = head + 4'd1;
					end else begin
						slot           = head + 4'(count - 1'b1);
						r.popped_value = ring[slot];
					end
					count = count - 1'b1;
					// last element gone: ring restarts at slot zero
					if (count == 0)
						head = '0;
				end
			end
			r.occupancy = count;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic signed [bde_pkg::WORD_W-1:0] popped, logic [1:0] st,
				logic [bde_pkg::OCC_W-1:0] occ);
			deque_result_t r;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result word: popped %0d status %0d occupancy %0d",
					$time, popped, st, occ);
				errors++;
				return;
			end
			r = expected_results.pop_front();
			if (popped !== r.popped_value) begin
				$display("%0t: popped_value mismatch: expected %0d actual %0d",
					$time, r.popped_value, popped);
				errors++;
			end
			if (st !== r.status) begin
				$display("%0t: status mismatch: expected %0d actual %0d",
					$time, r.status, st);
				errors++;
			end
			if (occ !== r.occupancy) begin
				$display("%0t: occupancy mismatch: expected %0d actual %0d",
					$time, r.occupancy, occ);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic [1:0]                        operation = bde_pkg::OP_PUSH_FRONT;
	logic signed [bde_pkg::WORD_W-1:0] push_value = '0;
	logic                              busy;
	logic                              done;
	logic signed [bde_pkg::WORD_W-1:0] popped_value;
	logic [1:0]                        status;
	logic [bde_pkg::OCC_W-1:0]         occupancy;

	deque_scoreboard sb;
	int unsigned     idle_cycles = 0;

	bounded_deque_engine #(.DEPTH(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.push_value   (push_value),
		.done         (done),
		.popped_value (popped_value),
		.status       (status),
		.occupancy    (occupancy)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(popped_value, status, occupancy);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("bounded_deque_engine regression: fail");
				$finish;
			end
		end
	end

	// called just after a falling edge; returns just after a falling edge
	task automatic issue(bde_pkg::op_t op, logic signed [bde_pkg::WORD_W-1:0] word,
			int unsigned gap);
		repeat (gap) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		push_value <= word;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(op, word);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic logic signed [bde_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned  issued;
		int unsigned  phase_len;
		int unsigned  mode;
		bit           no_idle;
		bde_pkg::op_t op;

		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty deque refuses both pops
		issue(bde_pkg::OP_POP_FRONT, 32'sh7fff_ffff, 0);
		issue(bde_pkg::OP_POP_BACK, -32'sd1, 0);
		issue(bde_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff, 0);
		issue(bde_pkg::OP_PUSH_BACK, 32'sh8000_0000, 1);
		issue(bde_pkg::OP_POP_FRONT, '0, 0);
		issue(bde_pkg::OP_POP_BACK, '0, 0);
		// fill from both ends so the head wraps, then hit full on both pushes
		for (int i = 0; i < DEPTH; i++)
			issue(bde_pkg::op_t'(i % 2), (i % 3 == 0) ? -32'sd1 - i : 32'sh5a5a_0000 + i, 0);
		issue(bde_pkg::OP_PUSH_FRONT, 32'sh1234_5678, 0);
		issue(bde_pkg::OP_PUSH_BACK, -32'sd1, 2);
		drain_results();

		issued = 0;
		while (issued < RANDOM_OPS) begin
			phase_len = $urandom_range(40, 120);
			mode      = $urandom_range(0, 2);
			no_idle   = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < phase_len; i++) begin
				case (mode)
					0:       op = ($urandom_range(0, 3) != 0)
							? bde_pkg::op_t'($urandom_range(0, 1))
							: bde_pkg::op_t'($urandom_range(2, 3));
					1:       op = ($urandom_range(0, 3) != 0)
							? bde_pkg::op_t'($urandom_range(2, 3))
							: bde_pkg::op_t'($urandom_range(0, 1));
					default: op = bde_pkg::op_t'($urandom_range(0, 3));
				endcase
				issue(op, pick_word(), no_idle ? 0 : $urandom_range(0, 13));
			end
			issued += phase_len;
			if (issued == phase_len || $urandom_range(0, 1) == 0)
				drain_results();
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("bounded_deque_engine regression: pass");
		else
			$display("bounded_deque_engine regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/bde_pkg.sv
rtl/core/bde_ram.sv
rtl/core/bounded_deque_engine.sv
tb/sv/testbench.sv
